### hdl/trca_pkg.sv
// ----------------------------------------------------------------------------
// trca_pkg: shared types and constants of the rotation-center angle block
// Widths, the CORDIC arctangent table and the words handed between cells.
// ----------------------------------------------------------------------------
package trca_pkg;

    // Input speed width and CORDIC depth.
    localparam int DATA_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;

    // Fixed widths of the register and the result fields.
    localparam int THR_W   = 15;
    localparam int THR2_W  = 2 * THR_W;
    localparam int ANGLE_W = 16;

    // Internal formats.
    localparam int GUARD_BITS = 20;
    localparam int ACC_W      = 32;
    localparam int CORDIC_W   = DATA_WIDTH + GUARD_BITS + 4;
    localparam int SQ_W       = 2 * DATA_WIDTH;
    localparam int SQ_POS_W   = $clog2(SQ_W);
    localparam int SHIFT_W    = 5;
    localparam int ATAN_DEPTH = 32;

    // Binary-angle constants (2^32 is a full turn in the accumulator).
    localparam logic [ACC_W-1:0]   QUARTER_POS = 32'h4000_0000;
    localparam logic [ACC_W-1:0]   QUARTER_NEG = 32'hC000_0000;
    localparam logic [ACC_W-1:0]   ROUND_HALF  = 32'h0000_8000;
    localparam logic [ANGLE_W-1:0] ELEV_UP     = 16'h4000;
    localparam logic [ANGLE_W-1:0] ELEV_DOWN   = 16'hC000;

    // round(atan(2^-i) * 2^31 / pi) for each micro-rotation.
    localparam logic [ACC_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Raw speeds and early decisions that ride along the square-root cells.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] speed_x;
        logic signed [DATA_WIDTH-1:0] speed_y;
        logic signed [DATA_WIDTH-1:0] turn_rate;
        logic                         heading_zero;
        logic                         elev_small;
    } trca_side_t;

    // Word of one square-root cell: remainder, partial root and side data.
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        trca_side_t      side;
    } trca_sqrt_t;

    // Word of one CORDIC lane.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ACC_W-1:0]           z;
    } trca_vec_t;

    // Result selection flags that travel beside the CORDIC lanes.
    typedef struct packed {
        logic heading_zero;
        logic elev_small;
        logic turn_pos;
        logic turn_neg;
    } trca_flags_t;

    // Arctangent of one micro-rotation.
    function automatic logic [ACC_W-1:0] atan_entry(input logic [SHIFT_W-1:0] idx);
        return ATAN_TABLE[idx];
    endfunction

endpackage

### hdl/twist_to_rotation_center_angles.sv
// ----------------------------------------------------------------------------
// twist_to_rotation_center_angles: rotation-center angles of a planar twist
// Fully pipelined: squares, integer square root cells, two CORDIC lanes.
// ----------------------------------------------------------------------------
// The block takes one velocity word per clock while the output is not
// stalled and returns the heading and elevation of the instantaneous
// rotation center as 16-bit binary angles. Each word passes through one
// stage of squares, one of sums and threshold compares, one square-root
// cell per root bit, one pre-rotation stage, one CORDIC cell per
// micro-rotation and the output register. The whole row of cells advances
// together whenever the output register is free or being read; a one-word
// input buffer keeps s_tready high after the output stalls until it holds
// a word. The threshold register may be rewritten only while no word
// is in flight.
// ----------------------------------------------------------------------------
module twist_to_rotation_center_angles
    import trca_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration: small_speed_threshold.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [THR_W-1:0]        cfg_data,
    // Input words.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // speed_x, speed_y, turn_rate, from the lowest bit up.
    input  logic [3*DATA_WIDTH-1:0] s_tdata,
    // Result words.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // heading_angle, elevation_angle, from the lowest bit up.
    output logic [2*ANGLE_W-1:0]    m_tdata
);

    localparam int PIPE_DEPTH = 3 + DATA_WIDTH + CORDIC_STAGES;
    localparam int MAG_CMP_W  = (DATA_WIDTH > THR_W) ? DATA_WIDTH : THR_W;
    localparam int SQ_CMP_W   = (SQ_W > THR2_W) ? SQ_W : THR2_W;

    // Control state.
    logic [THR_W-1:0]        thr_reg;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [3*DATA_WIDTH-1:0] skid_data_reg;
    logic [PIPE_DEPTH-1:0]   pipe_valid_reg;
    logic                    m_tvalid_reg;

    // Pipeline control.
    logic                    en;
    logic                    s_accept;
    logic                    in_valid;
    logic [3*DATA_WIDTH-1:0] in_data;

    // Stage A: magnitudes and squares.
    logic signed [DATA_WIDTH-1:0] in_speed_x;
    logic signed [DATA_WIDTH-1:0] in_speed_y;
    logic signed [DATA_WIDTH-1:0] in_turn_rate;
    logic [DATA_WIDTH-1:0]        abs_x;
    logic [DATA_WIDTH-1:0]        abs_y;
    logic signed [DATA_WIDTH-1:0] a_speed_x_reg;
    logic signed [DATA_WIDTH-1:0] a_speed_y_reg;
    logic signed [DATA_WIDTH-1:0] a_turn_rate_reg;
    logic [SQ_W-1:0]              a_x2_reg;
    logic [SQ_W-1:0]              a_y2_reg;
    logic [THR2_W-1:0]            a_thr2_reg;
    logic                         a_heading_zero_reg;

    // Stage B and the square-root cells.
    logic [SQ_W-1:0] b_sq;
    trca_sqrt_t      sqrt_next;
    trca_sqrt_t      sqrt_pipe [0:DATA_WIDTH];

    // Pre-rotation and the CORDIC lanes.
    trca_side_t                 last_side;
    logic [DATA_WIDTH-1:0]      last_root;
    logic signed [CORDIC_W-1:0] h_x_scaled;
    logic signed [CORDIC_W-1:0] h_y_scaled;
    logic signed [CORDIC_W-1:0] e_x_scaled;
    logic signed [CORDIC_W-1:0] e_y_scaled;
    trca_vec_t                  head_vec_next;
    trca_vec_t                  elev_vec_next;
    trca_flags_t                flags_next;
    trca_vec_t                  head_vec  [0:CORDIC_STAGES];
    trca_vec_t                  elev_vec  [0:CORDIC_STAGES];
    trca_flags_t                flags_reg [0:CORDIC_STAGES];

    // Output stage.
    logic [ACC_W-1:0]     head_round;
    logic [ACC_W-1:0]     elev_round;
    logic [ANGLE_W-1:0]   heading_next;
    logic [ANGLE_W-1:0]   elevation_next;
    logic [2*ANGLE_W-1:0] m_tdata_reg;

    // Threshold register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // The whole row moves when the output register is free or being read.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign in_valid = skid_valid_reg || s_accept;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    // Input buffer catches one word while the row is stalled.
    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg || s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && !en) begin
            skid_data_reg <= s_tdata;
        end
    end

    // Valid bits of every stage shift along with the payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            pipe_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (en) begin
                pipe_valid_reg <= {pipe_valid_reg[PIPE_DEPTH-2:0], in_valid};
                m_tvalid_reg   <= pipe_valid_reg[PIPE_DEPTH-1];
            end
        end
    end

    // Stage A: absolute values, squares and the pure-rotation test.
    always_comb begin
        in_speed_x   = in_data[DATA_WIDTH-1:0];
        in_speed_y   = in_data[2*DATA_WIDTH-1:DATA_WIDTH];
        in_turn_rate = in_data[3*DATA_WIDTH-1:2*DATA_WIDTH];
        abs_x        = in_speed_x[DATA_WIDTH-1] ? DATA_WIDTH'(-in_speed_x)
                                                : DATA_WIDTH'(in_speed_x);
        abs_y        = in_speed_y[DATA_WIDTH-1] ? DATA_WIDTH'(-in_speed_y)
                                                : DATA_WIDTH'(in_speed_y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_speed_x_reg      <= in_speed_x;
            a_speed_y_reg      <= in_speed_y;
            a_turn_rate_reg    <= in_turn_rate;
            a_x2_reg           <= SQ_W'(abs_x) * SQ_W'(abs_x);
            a_y2_reg           <= SQ_W'(abs_y) * SQ_W'(abs_y);
            a_thr2_reg         <= THR2_W'(thr_reg) * THR2_W'(thr_reg);
            a_heading_zero_reg <= (MAG_CMP_W'(abs_x) <= MAG_CMP_W'(thr_reg))
                                  && (in_speed_y == '0);
        end
    end

    // Stage B: planar speed square and the small-speed test.
    always_comb begin
        b_sq                        = a_x2_reg + a_y2_reg;
        sqrt_next.rem               = b_sq;
        sqrt_next.root              = '0;
        sqrt_next.side.speed_x      = a_speed_x_reg;
        sqrt_next.side.speed_y      = a_speed_y_reg;
        sqrt_next.side.turn_rate    = a_turn_rate_reg;
        sqrt_next.side.heading_zero = a_heading_zero_reg;
        sqrt_next.side.elev_small   = (SQ_CMP_W'(b_sq) <= SQ_CMP_W'(a_thr2_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqrt_pipe[0] <= sqrt_next;
        end
    end

    // Square-root cells, most significant root bit first.
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_sqrt
        trca_sqrt_cell u_sqrt_cell (
            .aclk     (aclk),
            .en       (en),
            .bit_pos  (SQ_POS_W'(2 * (DATA_WIDTH - 1 - k))),
            .cell_in  (sqrt_pipe[k]),
            .cell_out (sqrt_pipe[k+1])
        );
    end

    // Pre-rotation: scale both vectors and bring x into the right half-plane.
    always_comb begin
        last_side  = sqrt_pipe[DATA_WIDTH].side;
        last_root  = sqrt_pipe[DATA_WIDTH].root[DATA_WIDTH-1:0];
        h_x_scaled = CORDIC_W'(last_side.speed_x) <<< GUARD_BITS;
        h_y_scaled = CORDIC_W'(last_side.speed_y) <<< GUARD_BITS;
        e_x_scaled = $signed(CORDIC_W'(last_root)) <<< GUARD_BITS;
        e_y_scaled = CORDIC_W'(last_side.turn_rate) <<< GUARD_BITS;

        head_vec_next.x = h_x_scaled;
        head_vec_next.y = h_y_scaled;
        head_vec_next.z = '0;
        if (h_x_scaled < 0) begin
            if (h_y_scaled >= 0) begin
                head_vec_next.x = h_y_scaled;
                head_vec_next.y = -h_x_scaled;
                head_vec_next.z = QUARTER_POS;
            end else begin
                head_vec_next.x = -h_y_scaled;
                head_vec_next.y = h_x_scaled;
                head_vec_next.z = QUARTER_NEG;
            end
        end

        // The magnitude is never negative, so this lane needs no turn.
        elev_vec_next.x = e_x_scaled;
        elev_vec_next.y = e_y_scaled;
        elev_vec_next.z = '0;

        flags_next.heading_zero = last_side.heading_zero;
        flags_next.elev_small   = last_side.elev_small;
        flags_next.turn_pos     = (last_side.turn_rate > 0);
        flags_next.turn_neg     = last_side.turn_rate[DATA_WIDTH-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            head_vec[0]  <= head_vec_next;
            elev_vec[0]  <= elev_vec_next;
            flags_reg[0] <= flags_next;
        end
    end

    // Two CORDIC lanes side by side, one cell per micro-rotation.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        trca_cordic_cell u_head_cell (
            .aclk     (aclk),
            .en       (en),
            .shift    (SHIFT_W'(k)),
            .cell_in  (head_vec[k]),
            .cell_out (head_vec[k+1])
        );

        trca_cordic_cell u_elev_cell (
            .aclk     (aclk),
            .en       (en),
            .shift    (SHIFT_W'(k)),
            .cell_in  (elev_vec[k]),
            .cell_out (elev_vec[k+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                flags_reg[k+1] <= flags_reg[k];
            end
        end
    end

    // Round the accumulators to 16 bits and apply the special cases.
    always_comb begin
        head_round = head_vec[CORDIC_STAGES].z + ROUND_HALF;
        elev_round = elev_vec[CORDIC_STAGES].z + ROUND_HALF;

        if (flags_reg[CORDIC_STAGES].heading_zero) begin
            heading_next = '0;
        end else begin
            heading_next = head_round[ACC_W-1:ACC_W-ANGLE_W];
        end

        if (!flags_reg[CORDIC_STAGES].elev_small) begin
            elevation_next = elev_round[ACC_W-1:ACC_W-ANGLE_W];
        end else if (flags_reg[CORDIC_STAGES].turn_pos) begin
            elevation_next = ELEV_UP;
        end else if (flags_reg[CORDIC_STAGES].turn_neg) begin
            elevation_next = ELEV_DOWN;
        end else begin
            elevation_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {elevation_next, heading_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/trca_sqrt_cell.sv
// ----------------------------------------------------------------------------
// trca_sqrt_cell: one step of the integer square root
// Resolves one root bit of the planar speed square and passes the word on.
// ----------------------------------------------------------------------------
module trca_sqrt_cell
    import trca_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [SQ_POS_W-1:0] bit_pos,
    input  trca_sqrt_t          cell_in,
    output trca_sqrt_t          cell_out
);

    logic [SQ_W-1:0] bit_val;
    logic [SQ_W-1:0] trial;
    trca_sqrt_t      cell_next;
    trca_sqrt_t      cell_reg;

    // Try to set the current root bit; keep it when the remainder allows.
    always_comb begin
        bit_val   = SQ_W'(1) << bit_pos;
        trial     = cell_in.root + bit_val;
        cell_next = cell_in;
        if (cell_in.rem >= trial) begin
            cell_next.rem  = cell_in.rem - trial;
            cell_next.root = (cell_in.root >> 1) + bit_val;
        end else begin
            cell_next.root = cell_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

### hdl/trca_cordic_cell.sv
// ----------------------------------------------------------------------------
// trca_cordic_cell: one vectoring CORDIC micro-rotation
// Turns the vector toward the positive x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module trca_cordic_cell
    import trca_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [SHIFT_W-1:0] shift,
    input  trca_vec_t          cell_in,
    output trca_vec_t          cell_out
);

    logic signed [CORDIC_W-1:0] x_in;
    logic signed [CORDIC_W-1:0] y_in;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic [ACC_W-1:0]           step_angle;
    trca_vec_t                  cell_next;
    trca_vec_t                  cell_reg;

    // Rotate by the stage angle in the direction that drives y toward zero.
    always_comb begin
        x_in       = cell_in.x;
        y_in       = cell_in.y;
        x_sh       = x_in >>> shift;
        y_sh       = y_in >>> shift;
        step_angle = atan_entry(shift);
        if (y_in > 0) begin
            cell_next.x = x_in + y_sh;
            cell_next.y = y_in - x_sh;
            cell_next.z = cell_in.z + step_angle;
        end else begin
            cell_next.x = x_in - y_sh;
            cell_next.y = y_in + x_sh;
            cell_next.z = cell_in.z - step_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
